// ----- rtl/jsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// jsfe_pkg - shared definitions for the JSON string field extractor
// Constants, parse phase codes, register indexes and the result item type.
// ----------------------------------------------------------------------------
package jsfe_pkg;

   localparam int MAX_KEY_BYTES   = 8;
   localparam int KEY_CHARS_WIDTH = 64;
   localparam int KEY_LEN_WIDTH   = 4;
   localparam int CAPACITY_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_CHARS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAPACITY   = 2'd2;

   // characters
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;

   typedef enum logic [2:0] {
      PH_SEARCH       = 3'd0,
      PH_BEFORE_COLON = 3'd1,
      PH_BEFORE_QUOTE = 3'd2,
      PH_VALUE        = 3'd3,
      PH_ESCAPE       = 3'd4,
      PH_IDLE         = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0]                value_byte;
      logic                      value_valid;
      logic                      line_done;
      logic                      success;
      logic [CAPACITY_WIDTH-1:0] value_length;
   } rsp_type;

endpackage

// ----- rtl/jsfe_req_if.sv -----
// ----------------------------------------------------------------------------
// jsfe_req_if - input byte channel
// One text byte per item, with a flag on the last byte of the line.
// ----------------------------------------------------------------------------
interface jsfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       line_end;

   modport source (output valid, output line_byte, output line_end, input ready);
   modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

// ----- rtl/jsfe_rsp_if.sv -----
// ----------------------------------------------------------------------------
// jsfe_rsp_if - result channel
// One result item per input byte: decoded value byte and line summary.
// ----------------------------------------------------------------------------
interface jsfe_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [7:0]                           value_byte;
   logic                                 value_valid;
   logic                                 line_done;
   logic                                 success;
   logic [jsfe_pkg::CAPACITY_WIDTH-1:0]  value_length;

   modport source (output valid, output value_byte, output value_valid,
                   output line_done, output success, output value_length,
                   input ready);
   modport sink   (input valid, input value_byte, input value_valid,
                   input line_done, input success, input value_length,
                   output ready);
endinterface

// ----- rtl/jsfe_csr_if.sv -----
// ----------------------------------------------------------------------------
// jsfe_csr_if - configuration write channel
// Register index and write data, accepted on valid and ready.
// ----------------------------------------------------------------------------
interface jsfe_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [jsfe_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [jsfe_pkg::KEY_CHARS_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/json_string_field_extractor.sv -----
// ----------------------------------------------------------------------------
// json_string_field_extractor - pull one quoted string value out of a line
// Finds "key" in a byte stream, checks the colon and opening quote, then
// emits the decoded value bytes, one result item per input byte.
// ----------------------------------------------------------------------------
//
//   channel  | role    | payload
//   ---------+---------+-----------------------------------------------------
//   req_ch   | sink    | line_byte[7:0], line_end
//   rsp_ch   | source  | value_byte[7:0], value_valid, line_done, success,
//            |         | value_length[15:0]
//   csr_ch   | sink    | index[1:0] (0 key_chars, 1 key_length, 2 capacity),
//            |         | data[63:0]; always ready
//
// One item per cycle while req_ch is ready: the window compare and the phase
// update run in the cycle an item is accepted, and the result is registered
// in the output register, or in the skid entry while rsp_ch stalls.
// Synchronous active-high reset clears phase, counts and config registers.
// A stalled result is held in a one-entry skid stage; req_ch drops ready
// only while that skid entry is full.

module json_string_field_extractor #(
   parameter int MAX_KEY_BYTES = jsfe_pkg::MAX_KEY_BYTES
) (
   input  logic            clock,
   input  logic            reset,
   jsfe_req_if.sink        req_ch,
   jsfe_rsp_if.source      rsp_ch,
   jsfe_csr_if.sink        csr_ch
);

   localparam int DEPTH  = MAX_KEY_BYTES + 2;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int CAP_W  = jsfe_pkg::CAPACITY_WIDTH;

   // configuration
   logic [jsfe_pkg::KEY_CHARS_WIDTH-1:0] key_chars_ff;
   logic [jsfe_pkg::KEY_LEN_WIDTH-1:0]   key_length_ff;
   logic [CAP_W-1:0]                     capacity_ff;

   // per-line parse state
   jsfe_pkg::phase_type      phase_ff, phase_in;
   logic [DEPTH-1:0][7:0]    window_ff, window_in, window_shift;
   logic [FILL_W-1:0]        fill_ff, fill_in, fill_shift;
   logic [CAP_W-1:0]         kept_ff, kept_in;

   logic              accept;
   logic              req_ready;
   logic              key_hit;
   logic              want_emit;
   logic              emit;
   logic [7:0]        emit_byte;
   logic [7:0]        c;
   logic              is_space;
   jsfe_pkg::rsp_type result;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = req_ready;
   assign accept       = req_ch.valid && req_ready;
   assign c            = req_ch.line_byte;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         key_chars_ff  <= '0;
         key_length_ff <= '0;
         capacity_ff   <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            jsfe_pkg::CSR_KEY_CHARS:  key_chars_ff  <= csr_ch.data;
            jsfe_pkg::CSR_KEY_LENGTH: key_length_ff <=
               csr_ch.data[jsfe_pkg::KEY_LEN_WIDTH-1:0];
            jsfe_pkg::CSR_CAPACITY:   capacity_ff   <= csr_ch.data[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // shift the new byte into the window, newest at lane zero
   always_comb begin
      window_shift[0] = c;
      for (int i = 1; i < DEPTH; i++) begin
         window_shift[i] = window_ff[i-1];
      end
      if (int'(fill_ff) < DEPTH) begin
         fill_shift = fill_ff + FILL_W'(1);
      end else begin
         fill_shift = fill_ff;
      end
   end

   jsfe_key_match #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .DEPTH         (DEPTH),
      .FILL_W        (FILL_W)
   ) u_key_match (
      .window     (window_shift),
      .fill       (fill_shift),
      .key_chars  (key_chars_ff),
      .key_length (key_length_ff),
      .match      (key_hit)
   );

   assign is_space = (c == jsfe_pkg::CHAR_SPACE) ||
                     ((c >= jsfe_pkg::CHAR_TAB) && (c <= jsfe_pkg::CHAR_CR));

   // phase update and value decode for the byte at the input
   always_comb begin
      phase_in  = phase_ff;
      window_in = window_ff;
      fill_in   = fill_ff;
      want_emit = 1'b0;
      emit_byte = c;
      case (phase_ff)
         jsfe_pkg::PH_SEARCH: begin
            if (c == jsfe_pkg::CHAR_NUL) begin
               phase_in = jsfe_pkg::PH_IDLE;
            end else begin
               window_in = window_shift;
               fill_in   = fill_shift;
               if (key_hit) begin
                  phase_in = jsfe_pkg::PH_BEFORE_COLON;
               end
            end
         end
         jsfe_pkg::PH_BEFORE_COLON: begin
            if (c == jsfe_pkg::CHAR_COLON) begin
               phase_in = jsfe_pkg::PH_BEFORE_QUOTE;
            end else if (!is_space) begin
               phase_in = jsfe_pkg::PH_IDLE;
            end
         end
         jsfe_pkg::PH_BEFORE_QUOTE: begin
            if (c == jsfe_pkg::CHAR_QUOTE) begin
               phase_in = jsfe_pkg::PH_VALUE;
            end else if (!is_space) begin
               phase_in = jsfe_pkg::PH_IDLE;
            end
         end
         jsfe_pkg::PH_VALUE: begin
            if ((c == jsfe_pkg::CHAR_NUL) || (c == jsfe_pkg::CHAR_QUOTE)) begin
               phase_in = jsfe_pkg::PH_IDLE;
            end else if (c == jsfe_pkg::CHAR_BACKSLASH) begin
               phase_in = jsfe_pkg::PH_ESCAPE;
            end else begin
               want_emit = 1'b1;
            end
         end
         jsfe_pkg::PH_ESCAPE: begin
            if (c == jsfe_pkg::CHAR_NUL) begin
               phase_in = jsfe_pkg::PH_IDLE;
            end else begin
               phase_in  = jsfe_pkg::PH_VALUE;
               want_emit = 1'b1;
               if (c == jsfe_pkg::CHAR_LOWER_N) begin
                  emit_byte = jsfe_pkg::CHAR_LF;
               end else if (c == jsfe_pkg::CHAR_LOWER_R) begin
                  emit_byte = jsfe_pkg::CHAR_CR;
               end else if (c == jsfe_pkg::CHAR_LOWER_T) begin
                  emit_byte = jsfe_pkg::CHAR_TAB;
               end
            end
         end
         default: ;
      endcase

      // keep the byte only while room is left for the terminator
      emit    = want_emit &&
                (({1'b0, kept_ff} + (CAP_W+1)'(1)) < {1'b0, capacity_ff});
      kept_in = emit ? kept_ff + CAP_W'(1) : kept_ff;

      result.value_byte   = emit ? emit_byte : 8'd0;
      result.value_valid  = emit;
      result.line_done    = req_ch.line_end;
      result.success      = req_ch.line_end && (kept_in != '0);
      result.value_length = req_ch.line_end ? kept_in : '0;
   end

   // advance the parse state on each accepted byte; clear it at line end
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsfe_pkg::PH_SEARCH;
         fill_ff  <= '0;
         kept_ff  <= '0;
      end else if (accept) begin
         if (req_ch.line_end) begin
            phase_ff <= jsfe_pkg::PH_SEARCH;
            fill_ff  <= '0;
            kept_ff  <= '0;
         end else begin
            phase_ff <= phase_in;
            fill_ff  <= fill_in;
            kept_ff  <= kept_in;
         end
      end
   end

   // window lanes above the fill count are never compared
   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

   jsfe_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (req_ready),
      .in_data   (result),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  ({rsp_ch.value_byte, rsp_ch.value_valid, rsp_ch.line_done,
                   rsp_ch.success, rsp_ch.value_length})
   );

endmodule

// ----- rtl/jsfe_key_match.sv -----
// ----------------------------------------------------------------------------
// jsfe_key_match - quoted key compare against the byte window
// Flags when the newest bytes of the window spell "key" in double quotes.
// ----------------------------------------------------------------------------
module jsfe_key_match #(
   parameter int MAX_KEY_BYTES = jsfe_pkg::MAX_KEY_BYTES,
   parameter int DEPTH         = MAX_KEY_BYTES + 2,
   parameter int FILL_W        = $clog2(DEPTH + 1)
) (
   input  logic [DEPTH-1:0][7:0]                   window,
   input  logic [FILL_W-1:0]                       fill,
   input  logic [jsfe_pkg::KEY_CHARS_WIDTH-1:0]    key_chars,
   input  logic [jsfe_pkg::KEY_LEN_WIDTH-1:0]      key_length,
   output logic                                    match
);

   localparam int KLEN_W = $clog2(MAX_KEY_BYTES + 1);

   logic [KLEN_W-1:0]        klen_clamp;
   logic [KLEN_W-1:0]        klen_eff;
   logic                     zero_found;
   logic [MAX_KEY_BYTES:0]   cand_match;

   // clamp the length, then cut the key at its first zero byte
   always_comb begin
      if (key_length > jsfe_pkg::KEY_LEN_WIDTH'(MAX_KEY_BYTES)) begin
         klen_clamp = KLEN_W'(MAX_KEY_BYTES);
      end else begin
         klen_clamp = KLEN_W'(key_length);
      end
      klen_eff   = klen_clamp;
      zero_found = 1'b0;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
         if (!zero_found && (i < int'(klen_clamp)) &&
             (key_chars[8*i +: 8] == jsfe_pkg::CHAR_NUL)) begin
            klen_eff   = KLEN_W'(i);
            zero_found = 1'b1;
         end
      end
   end

   // one candidate compare per possible key length; window[0] is newest
   for (genvar k = 0; k <= MAX_KEY_BYTES; k++) begin : g_cand
      always_comb begin
         cand_match[k] = (window[0] == jsfe_pkg::CHAR_QUOTE) &&
                         (window[k+1] == jsfe_pkg::CHAR_QUOTE) &&
                         (int'(fill) >= k + 2);
         for (int j = 1; j <= k; j++) begin
            if (window[k+1-j] != key_chars[8*(j-1) +: 8]) begin
               cand_match[k] = 1'b0;
            end
         end
      end
   end

   assign match = cand_match[klen_eff];

endmodule

// ----- rtl/jsfe_out_skid.sv -----
// ----------------------------------------------------------------------------
// jsfe_out_skid - result register with skid stage
// Holds a stalled result in the skid stage; input stops while it is full.
// ----------------------------------------------------------------------------
module jsfe_out_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  jsfe_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output jsfe_pkg::rsp_type out_data
);

   logic              out_valid_ff;
   logic              skid_valid_ff;
   jsfe_pkg::rsp_type out_data_ff;
   jsfe_pkg::rsp_type skid_data_ff;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= in_valid;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else begin
            out_data_ff <= in_data;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_data_ff <= in_data;
      end
   end

endmodule
